FILE: sv/tkt_pkg.sv
// ----------------------------------------------------------------------------
// tkt_pkg: shared definitions for the top-K largest value tracker
// Field widths, register map, default sizes and the codes that the
// controller sends along the row of sorting cells.
// ----------------------------------------------------------------------------
package tkt_pkg;

   // Default sizes of the retained set and of one stored value.
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_VALUE_WIDTH = 32;

   // Fixed port field widths.
   localparam int IN_VALUE_W = 32;
   localparam int MIN_KEPT_W = 32;
   localparam int KEPT_CNT_W = 7;
   localparam int CAP_W      = 7;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index codes, taken from the word address bit.
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

   // Command that every cell of the row executes in a given cycle.
   typedef enum logic [1:0] {
      OP_HOLD     = 2'b00,
      OP_SHIFT_DN = 2'b01,
      OP_INSERT   = 2'b10,
      OP_REPLACE  = 2'b11
   } cell_op_type;

   // Controller sequence.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WORK = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   // What the controller needs to know about the smallest kept entry.
   typedef struct packed {
      logic valid;
      logic below;
   } root_status_type;

endpackage

FILE: sv/tkt_cell.sv
// ----------------------------------------------------------------------------
// tkt_cell: one slot of the sorted row of kept values
// Holds one value and its valid bit. The row is kept in ascending order
// with valid slots first, so every slot decides its next content from its
// own value, its two neighbors and the broadcast offered value.
// ----------------------------------------------------------------------------
module tkt_cell
   import tkt_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_op_type            op_i,
   input  logic [VALUE_WIDTH-1:0] value_i,
   input  logic [VALUE_WIDTH-1:0] prev_val_i,
   input  logic                   prev_valid_i,
   input  logic                   prev_le_i,
   input  logic [VALUE_WIDTH-1:0] next_val_i,
   input  logic                   next_valid_i,
   input  logic                   next_lt_i,
   output logic [VALUE_WIDTH-1:0] val_o,
   output logic                   valid_o,
   output logic                   le_o,
   output logic                   lt_o
);

   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   valid_ff, valid_in;
   logic                   le, lt;

   assign le = valid_ff && (val_ff <= value_i);
   assign lt = valid_ff && (val_ff < value_i);

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      unique case (op_i)
         OP_HOLD: begin
         end
         OP_SHIFT_DN: begin
            val_in   = next_val_i;
            valid_in = next_valid_i;
         end
         OP_INSERT: begin
            // Slots at or below the new value stay, the first larger one
            // takes it and the rest move up by one place.
            if (!le) begin
               if (prev_le_i) begin
                  val_in   = value_i;
                  valid_in = 1'b1;
               end else begin
                  val_in   = prev_val_i;
                  valid_in = prev_valid_i;
               end
            end
         end
         OP_REPLACE: begin
            // The smallest entry drops out and the new value slides into
            // its sorted place; the count is unchanged.
            if (next_lt_i) begin
               val_in = next_val_i;
            end else if (lt) begin
               val_in = value_i;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
   end

   assign val_o   = val_ff;
   assign valid_o = valid_ff;
   assign le_o    = le;
   assign lt_o    = lt;

endmodule

FILE: sv/tkt_ctrl.sv
// ----------------------------------------------------------------------------
// tkt_ctrl: request sequencer of the top-K tracker
// Takes a request, trims the kept set down to the capacity, issues the
// insert or replace command to the row and returns the summary result.
// ----------------------------------------------------------------------------
module tkt_ctrl
   import tkt_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [IN_VALUE_W-1:0]  req_value,
   input  logic [CNT_W-1:0]       eff_cap_i,
   input  root_status_type        root_i,
   input  logic [VALUE_WIDTH-1:0] root_val_i,
   output cell_op_type            op_o,
   output logic [VALUE_WIDTH-1:0] value_o,
   output logic [CNT_W-1:0]       count_o,
   output logic                   rsp_valid,
   output logic [MIN_KEPT_W-1:0]  rsp_min_kept,
   output logic [KEPT_CNT_W-1:0]  rsp_kept_count,
   output logic                   rsp_is_empty
);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MIN_KEPT_W-1:0]  rsp_min_ff, rsp_min_in;
   logic [KEPT_CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   cell_op_type            op;

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_min_in   = rsp_min_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_empty_in = rsp_empty_ff;
      op           = OP_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = VALUE_WIDTH'(req_value);
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (count_ff > eff_cap_i) begin
               // Capacity was lowered: drop the smallest entry this cycle.
               op       = OP_SHIFT_DN;
               count_in = count_ff - CNT_W'(1);
            end else if (count_ff < eff_cap_i) begin
               op       = OP_INSERT;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_RESP;
            end else begin
               op       = root_i.below ? OP_REPLACE : OP_HOLD;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_min_in   = root_i.valid ? MIN_KEPT_W'(root_val_i) : '0;
            rsp_cnt_in   = KEPT_CNT_W'(count_ff);
            rsp_empty_in = (count_ff == '0);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign op_o           = op;
   assign value_o        = value_ff;
   assign count_o        = count_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_kept   = rsp_min_ff;
   assign rsp_kept_count = rsp_cnt_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

FILE: sv/top_k_largest_tracker_core.sv
// ----------------------------------------------------------------------------
// top_k_largest_tracker_core: keeps the largest values offered so far
// Retains up to a programmable number of the largest values and reports
// the smallest one kept, the count kept and an empty flag per request.
//
// Usage:
//   A request (req_value) is taken at a clock edge where start is high and
//   busy is low. Exactly one result per request appears on the rsp_ ports
//   for a single cycle, marked by rsp_valid; the receiver cannot stall it.
//   Busy drops in the cycle the result is shown, so a new request can be
//   taken while it is shown, but not before. The sequencer steps through
//   a work state in which the row of cells updates in parallel, a response
//   state that captures the row's smallest entry, and the result registers
//   that present it. After the capacity register was lowered below the kept
//   count, the first request stays busy while the surplus entries are
//   dropped, since the row drops one entry per cycle. The capacity register
//   (byte address 0) reads back the low seven bits as written; zero
//   acts as one and values above MAX_ENTRIES act as MAX_ENTRIES.
//   Reset empties the kept set and sets the capacity to 64.
// ----------------------------------------------------------------------------
module top_k_largest_tracker_core
   import tkt_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [IN_VALUE_W-1:0] req_value,
   output logic                  rsp_valid,
   output logic [MIN_KEPT_W-1:0] rsp_min_kept,
   output logic [KEPT_CNT_W-1:0] rsp_kept_count,
   output logic                  rsp_is_empty,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CAP_W-1:0]       capacity_ff, capacity_in;
   logic                   csr_wr;
   logic                   csr_idx;
   logic [CMP_W-1:0]       cap_ext;
   logic [CMP_W-1:0]       eff_cap_ext;
   logic [CNT_W-1:0]       eff_cap;
   logic [CNT_W-1:0]       count;
   cell_op_type            op;
   logic [VALUE_WIDTH-1:0] offered;
   root_status_type        root;

   logic [VALUE_WIDTH-1:0] cell_val [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_valid;
   logic [MAX_ENTRIES-1:0] cell_le;
   logic [MAX_ENTRIES-1:0] cell_lt;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && (csr_idx == CSR_IDX_CAPACITY)) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign csr_prdata = (csr_idx == CSR_IDX_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap_ext = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap_ext = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap_ext = cap_ext;
      end
   end

   assign eff_cap = CNT_W'(eff_cap_ext);

   // Row of sorted cells, smallest kept value in the first one.
   for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_val, next_val;
      logic                   prev_valid, prev_le, next_valid, next_lt;

      if (gi == 0) begin : g_first
         assign prev_val   = '0;
         assign prev_valid = 1'b0;
         assign prev_le    = 1'b1;
      end else begin : g_inner_prev
         assign prev_val   = cell_val[gi-1];
         assign prev_valid = cell_valid[gi-1];
         assign prev_le    = cell_le[gi-1];
      end

      if (gi == MAX_ENTRIES - 1) begin : g_last
         assign next_val   = '0;
         assign next_valid = 1'b0;
         assign next_lt    = 1'b0;
      end else begin : g_inner_next
         assign next_val   = cell_val[gi+1];
         assign next_valid = cell_valid[gi+1];
         assign next_lt    = cell_lt[gi+1];
      end

      tkt_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .op_i         (op),
         .value_i      (offered),
         .prev_val_i   (prev_val),
         .prev_valid_i (prev_valid),
         .prev_le_i    (prev_le),
         .next_val_i   (next_val),
         .next_valid_i (next_valid),
         .next_lt_i    (next_lt),
         .val_o        (cell_val[gi]),
         .valid_o      (cell_valid[gi]),
         .le_o         (cell_le[gi]),
         .lt_o         (cell_lt[gi])
      );
   end

   assign root.valid = cell_valid[0];
   assign root.below = cell_lt[0];

   tkt_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .eff_cap_i      (eff_cap),
      .root_i         (root),
      .root_val_i     (cell_val[0]),
      .op_o           (op),
      .value_o        (offered),
      .count_o        (count),
      .rsp_valid      (rsp_valid),
      .rsp_min_kept   (rsp_min_kept),
      .rsp_kept_count (rsp_kept_count),
      .rsp_is_empty   (rsp_is_empty)
   );

   // The valid slots always match the kept count.
   a_valid_matches_count : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count))
      else $error("valid cells disagree with kept count");

   // A result never reports more entries than the capacity allows.
   a_result_within_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CMP_W'(rsp_kept_count) <= eff_cap_ext))
      else $error("result count exceeds capacity");

   // The empty flag agrees with the reported count.
   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_kept_count == '0)))
      else $error("empty flag inconsistent with count");

   // A taken request keeps the block busy in the next cycle.
   a_busy_after_start : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without going busy");

endmodule
